FILE: hdl/otgw_pkg.sv
// shared types and constants for the overlapping tile grid walker
// no dependencies; used by every module of the block by scoped names

package otgw_pkg;

  localparam int COORD_BITS   = 20;
  localparam int CNT_BITS     = $clog2(COORD_BITS + 1);
  localparam int CFG_IDX_BITS = 3;

  // configuration register indexes
  typedef enum logic [CFG_IDX_BITS-1:0] {
    CFG_TILE_HEIGHT  = 3'd0,
    CFG_TILE_WIDTH   = 3'd1,
    CFG_IMAGE_HEIGHT = 3'd2,
    CFG_IMAGE_WIDTH  = 3'd3,
    CFG_OVERLAP      = 3'd4,
    CFG_EDGE_MODE    = 3'd5,
    CFG_EXTRA_RIGHT  = 3'd6,
    CFG_EXTRA_DOWN   = 3'd7
  } cfg_idx_t;

  // result status codes
  typedef enum logic [1:0] {
    STS_OK      = 2'd0,
    STS_INVALID = 2'd1,
    STS_NO_WALK = 2'd2
  } tile_sts_t;

  // controller to datapath commands
  typedef struct packed {
    logic      restart_load;  // snapshot settings, start column divide
    logic      col_plan;      // take column count, start row divide
    logic      row_plan;      // take row count
    logic      emit_tile;     // load current tile into output, advance
    logic      emit_err;      // load error result into output
    tile_sts_t err_code;
  } dp_cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic cfg_ok;
    logic div_done;
    logic walk_active;
  } dp_sts_t;

endpackage

FILE: hdl/otgw_div.sv
// iterative restoring divider, one quotient bit per cycle
// depends on otgw_pkg for the operand width

module otgw_div (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  input  logic [otgw_pkg::COORD_BITS-1:0] dividend,
  input  logic [otgw_pkg::COORD_BITS-1:0] divisor,
  output logic                           done,
  output logic [otgw_pkg::COORD_BITS-1:0] quot,
  output logic                           rem_nz
);

  localparam int W  = otgw_pkg::COORD_BITS;
  localparam int CB = otgw_pkg::CNT_BITS;

  logic [W-1:0]  quot_r, rem_r, div_r;
  logic [CB-1:0] cnt_r;
  logic [W:0]    shifted;
  logic [W+1:0]  diff;

  assign shifted = {rem_r, quot_r[W-1]};
  assign diff    = {1'b0, shifted} - {2'b00, div_r};
  assign done    = (cnt_r == CB'(W));
  assign quot    = quot_r;
  assign rem_nz  = |rem_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= CB'(W);
    end else if (start) begin
      cnt_r <= '0;
    end else if (!done) begin
      cnt_r <= cnt_r + CB'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quot_r <= dividend;
      rem_r  <= '0;
      div_r  <= divisor;
    end else if (!done) begin
      quot_r <= {quot_r[W-2:0], ~diff[W+1]};
      // negative trial keeps the shifted remainder
      rem_r  <= diff[W+1] ? shifted[W-1:0] : diff[W-1:0];
    end
  end

endmodule

FILE: hdl/otgw_ctrl.sv
// controller state machine: request handshake, divide sequencing, output register valid
// depends on otgw_pkg for command and status structs

module otgw_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic              in_restart,
  output logic              out_valid,
  input  logic              out_stall,
  input  otgw_pkg::dp_sts_t sts,
  output otgw_pkg::dp_cmd_t cmd
);

  typedef enum logic [3:0] {
    ST_IDLE    = 4'b0001,
    ST_DIV_COL = 4'b0010,
    ST_DIV_ROW = 4'b0100,
    ST_EMIT    = 4'b1000
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   slot_free, accept;

  assign slot_free = !out_valid_r || !out_stall;
  assign in_stall  = (state_r != ST_IDLE) || !slot_free;
  assign accept    = in_valid && !in_stall;
  assign out_valid = out_valid_r;

  always_comb begin
    state_nxt    = state_r;
    cmd          = '0;
    cmd.err_code = otgw_pkg::STS_OK;
    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          if (in_restart) begin
            if (sts.cfg_ok) begin
              cmd.restart_load = 1'b1;
              state_nxt        = ST_DIV_COL;
            end else begin
              cmd.emit_err = 1'b1;
              cmd.err_code = otgw_pkg::STS_INVALID;
            end
          end else if (sts.walk_active) begin
            cmd.emit_tile = 1'b1;
          end else begin
            cmd.emit_err = 1'b1;
            cmd.err_code = otgw_pkg::STS_NO_WALK;
          end
        end
      end
      ST_DIV_COL: begin
        if (sts.div_done) begin
          cmd.col_plan = 1'b1;
          state_nxt    = ST_DIV_ROW;
        end
      end
      ST_DIV_ROW: begin
        if (sts.div_done) begin
          cmd.row_plan = 1'b1;
          state_nxt    = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (slot_free) begin
          cmd.emit_tile = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    if (cmd.emit_tile || cmd.emit_err) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

FILE: hdl/otgw_dpath.sv
// datapath: settings registers, walk plan, tile position counters, output payload
// depends on otgw_pkg and instantiates otgw_div

module otgw_dpath (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_valid,
  input  logic [otgw_pkg::CFG_IDX_BITS-1:0]   cfg_index,
  input  logic [otgw_pkg::COORD_BITS-1:0]     cfg_data,
  input  otgw_pkg::dp_cmd_t                   cmd,
  output otgw_pkg::dp_sts_t                   sts,
  output logic [otgw_pkg::COORD_BITS-1:0]     out_tile_x,
  output logic [otgw_pkg::COORD_BITS-1:0]     out_tile_y,
  output logic [otgw_pkg::COORD_BITS-1:0]     out_tile_w,
  output logic [otgw_pkg::COORD_BITS-1:0]     out_tile_h,
  output logic                                out_last,
  output logic [1:0]                          out_status
);

  localparam int W = otgw_pkg::COORD_BITS;

  // settings registers
  logic [W-1:0] tile_height_r, tile_width_r, image_height_r, image_width_r, overlap_r;
  logic         edge_mode_r, extra_right_r, extra_down_r;

  // walk snapshot and plan
  logic [W-1:0] col_img_r, col_tile_r, row_img_r, row_tile_r, ov_r;
  logic [W-1:0] col_stride_r, row_stride_r, col_count_r, row_count_r;
  logic         mode_r, allow_col_r, allow_row_r, col_extra_r, row_extra_r;

  // walk position
  logic [W-1:0] col_index_r, row_index_r, x_pos_r, y_pos_r;
  logic         walk_active_r;

  // output payload
  logic [W-1:0] tile_x_r, tile_y_r, tile_w_r, tile_h_r;
  logic         last_r;
  logic [1:0]   status_r;

  logic         div_start, div_done, div_rem_nz;
  logic [W-1:0] div_dividend, div_divisor, div_quot;
  logic         ok_col, ok_row, extra_now;
  logic         col_last, row_last, fin;
  logic [W-1:0] cur_x, cur_y, cur_w, cur_h;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tile_height_r  <= '0;
      tile_width_r   <= '0;
      image_height_r <= '0;
      image_width_r  <= '0;
      overlap_r      <= '0;
      edge_mode_r    <= 1'b0;
      extra_right_r  <= 1'b1;
      extra_down_r   <= 1'b1;
    end else if (cfg_valid) begin
      unique case (otgw_pkg::cfg_idx_t'(cfg_index))
        otgw_pkg::CFG_TILE_HEIGHT:  tile_height_r  <= cfg_data;
        otgw_pkg::CFG_TILE_WIDTH:   tile_width_r   <= cfg_data;
        otgw_pkg::CFG_IMAGE_HEIGHT: image_height_r <= cfg_data;
        otgw_pkg::CFG_IMAGE_WIDTH:  image_width_r  <= cfg_data;
        otgw_pkg::CFG_OVERLAP:      overlap_r      <= cfg_data;
        otgw_pkg::CFG_EDGE_MODE:    edge_mode_r    <= cfg_data[0];
        otgw_pkg::CFG_EXTRA_RIGHT:  extra_right_r  <= cfg_data[0];
        otgw_pkg::CFG_EXTRA_DOWN:   extra_down_r   <= cfg_data[0];
        default: ;
      endcase
    end
  end

  assign ok_col = (image_width_r != '0) && (tile_width_r != '0) &&
                  (tile_width_r <= image_width_r) && (overlap_r < tile_width_r);
  assign ok_row = (image_height_r != '0) && (tile_height_r != '0) &&
                  (tile_height_r <= image_height_r) && (overlap_r < tile_height_r);

  // column divide starts from the live settings, row divide from the snapshot
  assign div_start    = cmd.restart_load || cmd.col_plan;
  assign div_dividend = cmd.restart_load ? (image_width_r - overlap_r) : (row_img_r - ov_r);
  assign div_divisor  = cmd.restart_load ? (tile_width_r - overlap_r) : row_stride_r;

  otgw_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .done     (div_done),
    .quot     (div_quot),
    .rem_nz   (div_rem_nz)
  );

  // a remainder means the regular grid stops short of the far edge
  assign extra_now = div_rem_nz && (!mode_r || (cmd.col_plan ? allow_col_r : allow_row_r));

  always_ff @(posedge clk) begin
    if (cmd.restart_load) begin
      col_img_r    <= image_width_r;
      col_tile_r   <= tile_width_r;
      row_img_r    <= image_height_r;
      row_tile_r   <= tile_height_r;
      ov_r         <= overlap_r;
      col_stride_r <= tile_width_r - overlap_r;
      row_stride_r <= tile_height_r - overlap_r;
      mode_r       <= edge_mode_r;
      allow_col_r  <= extra_right_r;
      allow_row_r  <= extra_down_r;
    end
    if (cmd.col_plan) begin
      col_extra_r <= extra_now;
      col_count_r <= div_quot + W'(extra_now);
    end
    if (cmd.row_plan) begin
      row_extra_r <= extra_now;
      row_count_r <= div_quot + W'(extra_now);
    end
  end

  assign col_last = ((W+1)'(col_index_r) + (W+1)'(1)) == (W+1)'(col_count_r);
  assign row_last = ((W+1)'(row_index_r) + (W+1)'(1)) == (W+1)'(row_count_r);
  assign fin      = col_last && row_last;

  always_comb begin
    if (mode_r) begin
      cur_x = (col_last && col_extra_r) ? (col_img_r - col_tile_r) : x_pos_r;
      cur_y = (row_last && row_extra_r) ? (row_img_r - row_tile_r) : y_pos_r;
      cur_w = col_tile_r;
      cur_h = row_tile_r;
    end else begin
      cur_x = x_pos_r;
      cur_y = y_pos_r;
      cur_w = col_last ? (col_img_r - x_pos_r) : col_tile_r;
      cur_h = row_last ? (row_img_r - y_pos_r) : row_tile_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      walk_active_r <= 1'b0;
      col_index_r   <= '0;
      row_index_r   <= '0;
      x_pos_r       <= '0;
      y_pos_r       <= '0;
    end else if (cmd.restart_load) begin
      walk_active_r <= 1'b1;
      col_index_r   <= '0;
      row_index_r   <= '0;
      x_pos_r       <= '0;
      y_pos_r       <= '0;
    end else if (cmd.emit_err) begin
      walk_active_r <= 1'b0;
    end else if (cmd.emit_tile) begin
      priority if (fin) begin
        walk_active_r <= 1'b0;
      end else if (col_last) begin
        col_index_r <= '0;
        x_pos_r     <= '0;
        row_index_r <= row_index_r + W'(1);
        y_pos_r     <= y_pos_r + row_stride_r;
      end else begin
        col_index_r <= col_index_r + W'(1);
        x_pos_r     <= x_pos_r + col_stride_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit_tile) begin
      tile_x_r <= cur_x;
      tile_y_r <= cur_y;
      tile_w_r <= cur_w;
      tile_h_r <= cur_h;
      last_r   <= fin;
      status_r <= otgw_pkg::STS_OK;
    end else if (cmd.emit_err) begin
      tile_x_r <= '0;
      tile_y_r <= '0;
      tile_w_r <= '0;
      tile_h_r <= '0;
      last_r   <= 1'b1;
      status_r <= cmd.err_code;
    end
  end

  assign sts.cfg_ok      = ok_col && ok_row;
  assign sts.div_done    = div_done;
  assign sts.walk_active = walk_active_r;

  assign out_tile_x = tile_x_r;
  assign out_tile_y = tile_y_r;
  assign out_tile_w = tile_w_r;
  assign out_tile_h = tile_h_r;
  assign out_last   = last_r;
  assign out_status = status_r;

endmodule

FILE: hdl/overlapping_tile_grid_walker.sv
// a next-tile request shows its result in the cycle after acceptance;
// a restart runs two passes of the bit-serial divider (column, then row) before its first tile
// throughput: one tile per cycle while the output is taken; the output register frees each cycle
// reset: synchronous active-low rst_n clears settings to their defaults and ends any walk
// depends on otgw_pkg, otgw_ctrl, otgw_dpath (with otgw_div)

module overlapping_tile_grid_walker (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic                              in_restart,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [otgw_pkg::COORD_BITS-1:0]   out_tile_x,
  output logic [otgw_pkg::COORD_BITS-1:0]   out_tile_y,
  output logic [otgw_pkg::COORD_BITS-1:0]   out_tile_w,
  output logic [otgw_pkg::COORD_BITS-1:0]   out_tile_h,
  output logic                              out_last,
  output logic [1:0]                        out_status,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [otgw_pkg::CFG_IDX_BITS-1:0] cfg_index,
  input  logic [otgw_pkg::COORD_BITS-1:0]   cfg_data
);

  otgw_pkg::dp_cmd_t cmd;
  otgw_pkg::dp_sts_t sts;

  // settings registers take a write every cycle
  assign cfg_ready = 1'b1;

  otgw_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_restart (in_restart),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .sts        (sts),
    .cmd        (cmd)
  );

  otgw_dpath u_dpath (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_valid  (cfg_valid && cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .cmd        (cmd),
    .sts        (sts),
    .out_tile_x (out_tile_x),
    .out_tile_y (out_tile_y),
    .out_tile_w (out_tile_w),
    .out_tile_h (out_tile_h),
    .out_last   (out_last),
    .out_status (out_status)
  );

endmodule

FILE: hdl/otgw_checker.sv
// port-level checks for the tile grid walker, bound to the top level
// depends on otgw_pkg and overlapping_tile_grid_walker

module otgw_checker (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            out_valid,
  input logic                            out_stall,
  input logic [otgw_pkg::COORD_BITS-1:0] out_tile_x,
  input logic [otgw_pkg::COORD_BITS-1:0] out_tile_y,
  input logic [otgw_pkg::COORD_BITS-1:0] out_tile_w,
  input logic [otgw_pkg::COORD_BITS-1:0] out_tile_h,
  input logic                            out_last,
  input logic [1:0]                      out_status
);

  // error results always close the walk
  a_err_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status != otgw_pkg::STS_OK) |-> out_last)
    else $error("error result without last");

  // error results carry no geometry
  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status != otgw_pkg::STS_OK) |->
      (out_tile_x == '0) && (out_tile_y == '0) && (out_tile_w == '0) && (out_tile_h == '0))
    else $error("error result with nonzero tile fields");

  // a real tile is never empty, even a truncated edge tile
  a_tile_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status == otgw_pkg::STS_OK) |-> (out_tile_w != '0) && (out_tile_h != '0))
    else $error("empty tile reported");

  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_status == otgw_pkg::STS_OK) || (out_status == otgw_pkg::STS_INVALID) ||
                  (out_status == otgw_pkg::STS_NO_WALK))
    else $error("unknown status code");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_tile_x) && $stable(out_tile_y) &&
                               $stable(out_last) && $stable(out_status))
    else $error("stalled result changed");

endmodule

bind overlapping_tile_grid_walker otgw_checker u_otgw_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_valid  (out_valid),
  .out_stall  (out_stall),
  .out_tile_x (out_tile_x),
  .out_tile_y (out_tile_y),
  .out_tile_w (out_tile_w),
  .out_tile_h (out_tile_h),
  .out_last   (out_last),
  .out_status (out_status)
);

FILE: dv/tb_top.sv
// testbench for overlapping_tile_grid_walker: directed and random tile walks, each reply
// checked against a scoreboard that models the walk from the accepted requests
// depends on otgw_pkg and the walker RTL

module tb_top;

  typedef logic [otgw_pkg::COORD_BITS-1:0] coord_t;

  typedef struct {
    coord_t     x, y, w, h;
    logic       last;
    logic [1:0] status;
  } tile_t;

  typedef struct {
    longint unsigned img, tile, stride, count;
    bit              has_edge;
  } axis_grid_t;

  typedef enum int {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_RUNS} stall_mode_t;

  localparam int     WATCHDOG_LIMIT = 4000;
  localparam int     ITEM_TARGET    = 1850;
  localparam coord_t COORD_MAX      = '1;

  class tile_walk_tracker;
    coord_t          tile_h, tile_w, img_h, img_w, ovl;
    bit              flush_mode, extra_right, extra_down;
    bit              walking, walk_flush;
    axis_grid_t      cols, rows;
    longint unsigned ci, ri;
    tile_t           tiles_due[$];
    int              n_mismatch, n_requests, n_restarts, n_tiles, n_walks;
    int              n_invalid, n_no_walk, n_flush_walks;

    function new();
      tile_h = '0; tile_w = '0; img_h = '0; img_w = '0; ovl = '0;
      flush_mode = 1'b0; extra_right = 1'b1; extra_down = 1'b1;
      walking = 1'b0; walk_flush = 1'b0;
      ci = 0; ri = 0;
    endfunction

    function void queue_reply(input tile_t r);
      tiles_due.insert(tiles_due.size(), r);
    endfunction

    function void write_reg(input otgw_pkg::cfg_idx_t idx, input coord_t d);
      case (idx)
        otgw_pkg::CFG_TILE_HEIGHT:  tile_h = d;
        otgw_pkg::CFG_TILE_WIDTH:   tile_w = d;
        otgw_pkg::CFG_IMAGE_HEIGHT: img_h = d;
        otgw_pkg::CFG_IMAGE_WIDTH:  img_w = d;
        otgw_pkg::CFG_OVERLAP:      ovl = d;
        otgw_pkg::CFG_EDGE_MODE:    flush_mode = d[0];
        otgw_pkg::CFG_EXTRA_RIGHT:  extra_right = d[0];
        otgw_pkg::CFG_EXTRA_DOWN:   extra_down = d[0];
        default: ;
      endcase
    endfunction

    function bit fits(input coord_t img, input coord_t tile, input coord_t ov);
      return img != 0 && tile != 0 && tile <= img && ov < tile;
    endfunction

    function axis_grid_t grid_axis(input coord_t img, input coord_t tile, input coord_t ov,
                                   input bit allow);
      axis_grid_t      a;
      longint unsigned n;
      a.img    = img;
      a.tile   = tile;
      a.stride = a.tile - ov;
      n = (a.img - ov) / a.stride;
      // edge tile when the regular grid stops short of the far edge
      a.has_edge = (n * a.stride + ov != a.img) && (!walk_flush || allow);
      a.count    = n + a.has_edge;
      return a;
    endfunction

    function void place(input axis_grid_t a, input longint unsigned idx,
                        output coord_t start, output coord_t extent);
      longint unsigned s;
      bit              at_end;
      at_end = (idx + 1 == a.count);
      s = a.stride * idx;
      if (walk_flush) begin
        if (at_end && a.has_edge) s = a.img - a.tile;
        extent = coord_t'(a.tile);
      end else begin
        extent = at_end ? coord_t'(a.img - s) : coord_t'(a.tile);
      end
      start = coord_t'(s);
    endfunction

    function void take_request(input logic restart);
      tile_t r;
      bit    fin;
      r.x = '0; r.y = '0; r.w = '0; r.h = '0;
      r.last   = 1'b1;
      r.status = otgw_pkg::STS_NO_WALK;
      n_requests++;
      if (restart) begin
        n_restarts++;
        if (!fits(img_w, tile_w, ovl) || !fits(img_h, tile_h, ovl)) begin
          walking  = 1'b0;
          r.status = otgw_pkg::STS_INVALID;
          n_invalid++;
          queue_reply(r);
          return;
        end
        walk_flush = flush_mode;
        cols = grid_axis(img_w, tile_w, ovl, extra_right);
        rows = grid_axis(img_h, tile_h, ovl, extra_down);
        ci = 0;
        ri = 0;
        walking = 1'b1;
        n_flush_walks += walk_flush;
      end
      if (!walking) begin
        n_no_walk++;
        queue_reply(r);
        return;
      end
      place(cols, ci, r.x, r.w);
      place(rows, ri, r.y, r.h);
      fin = (ci + 1 >= cols.count) && (ri + 1 >= rows.count);
      r.last   = fin;
      r.status = otgw_pkg::STS_OK;
      n_tiles++;
      queue_reply(r);
      if (fin) begin
        walking = 1'b0;
        n_walks++;
      end else begin
        ci++;
        if (ci >= cols.count) begin
          ci = 0;
          ri++;
        end
      end
    endfunction

    function void check_tile(input tile_t got);
      tile_t want;
      if (tiles_due.size() == 0) begin
        n_mismatch++;
        if (n_mismatch <= 10)
          $display("unexpected reply: x=%0d y=%0d w=%0d h=%0d last=%0d status=%0d",
                   got.x, got.y, got.w, got.h, got.last, got.status);
        return;
      end
      want = tiles_due.pop_front();
      if (got.x !== want.x || got.y !== want.y || got.w !== want.w || got.h !== want.h ||
          got.last !== want.last || got.status !== want.status) begin
        n_mismatch++;
        if (n_mismatch <= 10) begin
          $display("reply %0d wrong: expected x=%0d y=%0d w=%0d h=%0d last=%0d status=%0d",
                   n_tiles + n_invalid + n_no_walk - tiles_due.size(),
                   want.x, want.y, want.w, want.h, want.last, want.status);
          $display("  got      x=%0d y=%0d w=%0d h=%0d last=%0d status=%0d",
                   got.x, got.y, got.w, got.h, got.last, got.status);
        end
      end
    endfunction
  endclass

  logic                              clk = 1'b0;
  logic                              rst_n = 1'b0;
  logic                              in_valid = 1'b0;
  logic                              in_stall;
  logic                              in_restart = 1'b0;
  logic                              out_valid;
  logic                              out_stall = 1'b0;
  coord_t                            out_tile_x, out_tile_y, out_tile_w, out_tile_h;
  logic                              out_last;
  logic [1:0]                        out_status;
  logic                              cfg_valid = 1'b0;
  logic                              cfg_ready;
  logic [otgw_pkg::CFG_IDX_BITS-1:0] cfg_index = '0;
  coord_t                            cfg_data = '0;

  tile_walk_tracker walk = new();

  int          n_sent = 0;
  int          n_cfg_writes = 0;
  int          n_settings = 0;
  int          burst_left = 0;
  int          stall_left = 0;
  int          quiet_cycles = 0;
  stall_mode_t stall_mode = STALL_NONE;

  overlapping_tile_grid_walker u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_restart (in_restart),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_tile_x (out_tile_x),
    .out_tile_y (out_tile_y),
    .out_tile_w (out_tile_w),
    .out_tile_h (out_tile_h),
    .out_last   (out_last),
    .out_status (out_status),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // receiver stall pattern, switching style when each random-length run ends
  always @(posedge clk) begin
    if (stall_left == 0) begin
      stall_mode = stall_mode_t'($urandom_range(0, 3));
      stall_left = $urandom_range(20, 200);
    end else begin
      stall_left--;
    end
    case (stall_mode)
      STALL_NONE:  out_stall <= 1'b0;
      STALL_LIGHT: out_stall <= ($urandom_range(0, 3) == 0);
      STALL_HEAVY: out_stall <= ($urandom_range(0, 1) == 0);
      STALL_RUNS:  out_stall <= ((stall_left / 6) % 3 == 0);
      default:     out_stall <= 1'b0;
    endcase
  end

  always @(posedge clk) begin
    tile_t got;
    if (rst_n && out_valid && !out_stall) begin
      got.x      = out_tile_x;
      got.y      = out_tile_y;
      got.w      = out_tile_w;
      got.h      = out_tile_h;
      got.last   = out_last;
      got.status = out_status;
      walk.check_tile(got);
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
        quiet_cycles = 0;
      else
        quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("watchdog: no handshake for %0d cycles, %0d replies outstanding",
                 quiet_cycles, walk.tiles_due.size());
        $display("overlapping_tile_grid_walker: mismatch");
        $finish;
      end
    end
  end

  // one request, sent in bursts with random gaps in between
  task automatic send_request(input logic restart);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_valid   <= 1'b1;
    in_restart <= restart;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    walk.take_request(restart);
    n_sent++;
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (walk.tiles_due.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic program_settings(input coord_t th, tw, ih, iw, ov, input bit mode, er, ed,
                                  input logic [7:0] mask);
    coord_t word [8];
    word[otgw_pkg::CFG_TILE_HEIGHT]  = th;
    word[otgw_pkg::CFG_TILE_WIDTH]   = tw;
    word[otgw_pkg::CFG_IMAGE_HEIGHT] = ih;
    word[otgw_pkg::CFG_IMAGE_WIDTH]  = iw;
    word[otgw_pkg::CFG_OVERLAP]      = ov;
    // single-bit registers get junk in the unused upper bits
    word[otgw_pkg::CFG_EDGE_MODE]    = (coord_t'($urandom) & ~coord_t'(1)) | coord_t'(mode);
    word[otgw_pkg::CFG_EXTRA_RIGHT]  = (coord_t'($urandom) & ~coord_t'(1)) | coord_t'(er);
    word[otgw_pkg::CFG_EXTRA_DOWN]   = (coord_t'($urandom) & ~coord_t'(1)) | coord_t'(ed);
    for (int i = otgw_pkg::CFG_TILE_HEIGHT; i <= otgw_pkg::CFG_EXTRA_DOWN; i++) begin
      if (mask[i]) begin
        cfg_valid <= 1'b1;
        cfg_index <= otgw_pkg::cfg_idx_t'(i);
        cfg_data  <= word[i];
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        walk.write_reg(otgw_pkg::cfg_idx_t'(i), word[i]);
        n_cfg_writes++;
      end
    end
    cfg_valid <= 1'b0;
    n_settings++;
  endtask

  initial begin
    coord_t ih, iw, th, tw, ov, ov_cap;
    int     n_directed;

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset sizes and overlap are all zero: a restart is refused and nothing walks
    send_request(1'b0);
    send_request(1'b1);
    send_request(1'b0);
    drain_results();

    // largest image as one tile, overlap one below the tile
    program_settings(COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX, coord_t'(COORD_MAX - 1),
                     1'b0, 1'b1, 1'b1, 8'hFF);
    send_request(1'b1);
    send_request(1'b0);
    drain_results();

    // grid one pixel short on both axes: truncated edge tiles
    program_settings(coord_t'(COORD_MAX - 1), coord_t'(COORD_MAX - 1), COORD_MAX, COORD_MAX,
                     '0, 1'b0, 1'b1, 1'b1, 8'hFF);
    send_request(1'b1);
    repeat (3) send_request(1'b0);
    drain_results();

    // same grid with flush edge tiles
    program_settings(coord_t'(COORD_MAX - 1), coord_t'(COORD_MAX - 1), COORD_MAX, COORD_MAX,
                     '0, 1'b1, 1'b1, 1'b1, 8'd1 << otgw_pkg::CFG_EDGE_MODE);
    send_request(1'b1);
    repeat (3) send_request(1'b0);
    drain_results();

    // no flush tile on the right: one column, then the walk is over
    program_settings(coord_t'(COORD_MAX - 1), coord_t'(COORD_MAX - 1), COORD_MAX, COORD_MAX,
                     '0, 1'b1, 1'b0, 1'b1, 8'd1 << otgw_pkg::CFG_EXTRA_RIGHT);
    send_request(1'b1);
    repeat (2) send_request(1'b0);
    drain_results();

    // overlap equal to the tile
    program_settings(8, 8, 16, 16, 8, 1'b0, 1'b1, 1'b1, 8'hFF);
    send_request(1'b1);
    drain_results();
    // tile taller than the image
    program_settings(17, 8, 16, 16, 0, 1'b0, 1'b1, 1'b1, 8'hFF);
    send_request(1'b1);
    drain_results();
    // zero image width
    program_settings(8, 8, 16, 0, 0, 1'b0, 1'b1, 1'b1, 8'hFF);
    send_request(1'b1);
    drain_results();

    // small grid with a truncated column, restarted in the middle
    program_settings(3, 4, 5, 7, 2, 1'b0, 1'b1, 1'b1, 8'hFF);
    send_request(1'b1);
    repeat (2) send_request(1'b0);
    send_request(1'b1);

    n_directed = n_sent;
    while (n_sent - n_directed < ITEM_TARGET) begin
      drain_results();
      if ($urandom_range(0, 19) == 0) begin
        // near the top of the coordinate range, counts stay small
        ih = coord_t'(COORD_MAX - $urandom_range(0, 3));
        iw = coord_t'(COORD_MAX - $urandom_range(0, 3));
        th = coord_t'(ih - $urandom_range(0, 2));
        tw = coord_t'(iw - $urandom_range(0, 2));
      end else begin
        ih = coord_t'($urandom_range(1, 32));
        iw = coord_t'($urandom_range(1, 32));
        th = coord_t'($urandom_range((ih + 3) / 4, ih));
        tw = coord_t'($urandom_range((iw + 3) / 4, iw));
      end
      ov_cap = coord_t'(((th < tw) ? th : tw) - 1);
      case ($urandom_range(0, 3))
        0:       ov = '0;
        3:       ov = coord_t'($urandom_range(0, ov_cap));
        default: ov = coord_t'($urandom_range(0, ov_cap / 2));
      endcase
      // broken settings now and then
      if ($urandom_range(0, 9) == 0) begin
        case ($urandom_range(0, 3))
          0:       th = '0;
          1:       iw = '0;
          2:       ov = tw;
          default: th = coord_t'(ih + 1);
        endcase
      end
      program_settings(th, tw, ih, iw, ov, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                       1'($urandom_range(0, 1)),
                       ($urandom_range(0, 4) == 0) ? 8'($urandom) : 8'hFF);
      repeat ($urandom_range(1, 4)) begin
        // mostly a fresh walk, sometimes the one left over from the old settings
        send_request($urandom_range(0, 3) != 0);
        repeat ($urandom_range(0, 40)) send_request($urandom_range(0, 15) == 0);
        if ($urandom_range(0, 7) == 0) drain_results();
      end
    end

    drain_results();
    repeat (44) @(posedge clk);
    $display("covered %0d requests (%0d restarts) under %0d settings, %0d register writes",
             walk.n_requests, walk.n_restarts, n_settings, n_cfg_writes);
    $display("replies: %0d tiles, %0d walks finished (%0d flush-edge walks), %0d invalid, %0d idle",
             walk.n_tiles, walk.n_walks, walk.n_flush_walks, walk.n_invalid, walk.n_no_walk);
    if (walk.n_mismatch == 0 && walk.tiles_due.size() == 0) begin
      $display("overlapping_tile_grid_walker: match");
    end else begin
      $display("%0d wrong replies, %0d replies missing", walk.n_mismatch, walk.tiles_due.size());
      $display("overlapping_tile_grid_walker: mismatch");
    end
    $finish;
  end

endmodule
